// File: sv/gcl_pkg.sv
// Shared types and constants of the greedy container loading block.
package gcl_pkg;

	localparam int MAX_ITEMS   = 64;
	localparam int WEIGHT_BITS = 24;
	localparam int CAP_W       = 30;
	localparam int IDX_W       = $clog2(MAX_ITEMS);
	localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
	localparam int LOAD_W      = CAP_W + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;
	localparam int REG_W   = 1;

	localparam logic [REG_W-1:0] REG_CAPACITY = 1'b0;
	localparam logic [REG_W-1:0] REG_MODE     = 1'b1;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_RUN   = 1'b1;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic                   is_last;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]       item_index;
		logic [WEIGHT_BITS-1:0] item_weight;
		logic [CAP_W-1:0]       running_load;
		logic [CNT_W-1:0]       loaded_count;
		logic                   none_loaded;
		logic                   run_end;
	} result_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic                   op;
	} cmd_t;

endpackage

// File: sv/gcl_front.sv
// Input stage: takes transactions, classifies them and pushes them to the queue.
module gcl_front import gcl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  push,
	output cmd_t  cmd,
	input  logic  q_full
);

	logic stage_vld_s1;
	cmd_t stage_s1;
	logic accept;

	assign push       = stage_vld_s1 && !q_full;
	assign item_stall = stage_vld_s1 && q_full;
	assign accept     = item_valid && !item_stall;
	assign cmd        = stage_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_s1 <= 1'b0;
		end else if (accept) begin
			stage_vld_s1 <= 1'b1;
		end else if (push) begin
			stage_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.weight <= item.weight;
			stage_s1.op     <= item.is_last ? OP_RUN : OP_STORE;
		end
	end

endmodule

// File: sv/gcl_fifo.sv
// Short command queue between the input stage and the selection engine.
module gcl_fifo import gcl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic avail
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign avail   = count_q != '0;
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// File: sv/gcl_back.sv
// Selection engine: weight store, greedy scan rounds and result register.
module gcl_back import gcl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CAP_W-1:0] capacity,
	input  logic             mode,
	input  cmd_t             cmd,
	input  logic             cmd_avail,
	output logic             cmd_pop,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_PICK = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [WEIGHT_BITS-1:0] mem [MAX_ITEMS];

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       stored_q;
	logic [CNT_W-1:0]       scan_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [WEIGHT_BITS-1:0] rd_data_s1;
	logic                   best_vld_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [WEIGHT_BITS-1:0] lim_q;
	logic [CAP_W-1:0]       load_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [MAX_ITEMS-1:0]   taken_q;
	logic                   pend_vld_q;
	result_t                pend_q;
	logic                   res_vld_q;
	result_t                res_q;

	logic                   store_room;
	logic                   mem_we;
	logic                   rd_issue;
	logic [LOAD_W-1:0]      sum_rd;
	logic                   fits_rd;
	logic                   cand;
	logic [LOAD_W-1:0]      sum_best;
	logic                   pick_ok;
	logic                   slot_free;
	logic [CNT_W-1:0]       cnt_next;
	result_t                new_res;
	result_t                none_res;
	result_t                last_res;
	logic                   res_load;
	result_t                res_next;

	assign store_room = stored_q < CNT_W'(MAX_ITEMS);
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_avail;
	assign mem_we     = cmd_pop && store_room;
	assign rd_issue   = (state_q == ST_SCAN) && (scan_q < stored_q);

	// candidate test on the word read last cycle
	assign sum_rd  = {1'b0, load_q} + LOAD_W'(rd_data_s1);
	assign fits_rd = sum_rd <= {1'b0, capacity};
	always_comb begin
		if (mode) begin
			cand = !taken_q[rd_idx_s1] && (rd_data_s1 > lim_q) && fits_rd;
		end else begin
			cand = !taken_q[rd_idx_s1] && (!best_vld_q || rd_data_s1 < lim_q);
		end
	end

	assign sum_best  = {1'b0, load_q} + LOAD_W'(lim_q);
	assign pick_ok   = best_vld_q && (mode || sum_best <= {1'b0, capacity});
	assign slot_free = !res_vld_q || !result_stall;
	assign cnt_next  = cnt_q + 1'b1;

	always_comb begin
		new_res.item_index   = best_idx_q;
		new_res.item_weight  = lim_q;
		new_res.running_load = sum_best[CAP_W-1:0];
		new_res.loaded_count = cnt_next;
		new_res.none_loaded  = 1'b0;
		new_res.run_end      = 1'b0;
		none_res             = '0;
		none_res.none_loaded = 1'b1;
		none_res.run_end     = 1'b1;
		last_res             = pend_q;
		last_res.run_end     = 1'b1;
		res_load             = 1'b0;
		res_next             = last_res;
		// previous pick leaves once a later one exists, or when the run closes
		if (state_q == ST_PICK && pick_ok && pend_vld_q && slot_free) begin
			res_load = 1'b1;
			res_next = pend_q;
		end else if (state_q == ST_DONE && slot_free) begin
			res_load = 1'b1;
			res_next = pend_vld_q ? last_res : none_res;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[stored_q[IDX_W-1:0]] <= cmd.weight;
		rd_data_s1 <= mem[scan_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			stored_q   <= '0;
			scan_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			best_vld_q <= 1'b0;
			best_idx_q <= '0;
			lim_q      <= '0;
			load_q     <= '0;
			cnt_q      <= '0;
			taken_q    <= '0;
			pend_vld_q <= 1'b0;
			pend_q     <= '0;
			res_vld_q  <= 1'b0;
			res_q      <= '0;
		end else begin
			rd_vld_s1 <= rd_issue;
			rd_idx_s1 <= scan_q[IDX_W-1:0];
			if (res_load) begin
				res_q     <= res_next;
				res_vld_q <= 1'b1;
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (store_room) stored_q <= stored_q + 1'b1;
						if (cmd.op == OP_RUN) begin
							taken_q    <= '0;
							load_q     <= '0;
							cnt_q      <= '0;
							pend_vld_q <= 1'b0;
							scan_q     <= '0;
							best_vld_q <= 1'b0;
							lim_q      <= '0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_issue) scan_q <= scan_q + 1'b1;
					if (rd_vld_s1 && cand) begin
						best_vld_q <= 1'b1;
						best_idx_q <= rd_idx_s1;
						lim_q      <= rd_data_s1;
					end
					if (!rd_issue && !rd_vld_s1) state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (!pick_ok) begin
						state_q <= ST_DONE;
					end else if (!pend_vld_q || slot_free) begin
						taken_q[best_idx_q] <= 1'b1;
						load_q     <= sum_best[CAP_W-1:0];
						cnt_q      <= cnt_next;
						pend_q     <= new_res;
						pend_vld_q <= 1'b1;
						scan_q     <= '0;
						best_vld_q <= 1'b0;
						lim_q      <= '0;
						state_q    <= (cnt_next < stored_q) ? ST_SCAN : ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						pend_vld_q <= 1'b0;
						stored_q   <= '0;
						state_q    <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	a_load_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> load_q <= capacity)
		else $error("load above capacity during run");

	a_taken_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(taken_q) == int'(cnt_q))
		else $error("taken flags disagree with chosen count");

	a_cnt_le_stored: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> cnt_q <= stored_q)
		else $error("chosen count above stored count");

	a_pend_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> pend_q.loaded_count == cnt_q)
		else $error("held pick out of step with count");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.none_loaded |->
			res_q.run_end && res_q.loaded_count == '0 && res_q.running_load == '0)
		else $error("empty-run result carries data");

endmodule

// File: sv/greedy_container_loading_top.sv
// Top level of the greedy container loading block: APB registers and channel wiring.
//
// Usage:
//   Item channel (item_valid / item_stall / item): one container weight per
//   transaction, in load order. A transaction with is_last set closes the
//   batch and starts a selection run over the stored weights (up to
//   MAX_ITEMS; weights past that are dropped, is_last still starts the run).
//   Result channel (result_valid / result_stall / result): one transaction
//   per chosen container, the last one of a run flagged run_end. An empty
//   run gives a single transaction with none_loaded and run_end set.
//   APB: capacity at 0x0, mode at 0x4 (0 = lightest first, 1 = heaviest fit).
//   Write registers only while the block is idle.
// Throughput: weights are taken one per cycle while the queue has room; a 4-deep
//   command queue lets loading go on while a result waits. Each pick over N stored
//   weights reads all N from the store, drains the read, then picks; the run
//   closes after one more fruitless round unless all are taken.
// Results: a pick is held until the next pick or the close of the run.
// Reset: arst_n clears registers, queue and store count; store contents
//   are not cleared. A stalled result holds; the engine waits on it and the
//   queue then fills and stalls the item channel.
module greedy_container_loading_top import gcl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result
);

	logic [CAP_W-1:0] capacity_q;
	logic             mode_q;
	logic [REG_W-1:0] reg_idx;
	logic             reg_wr;

	logic push;
	cmd_t push_cmd;
	logic q_full;
	cmd_t head;
	logic avail;
	logic pop;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite;

	// register writes land in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			mode_q     <= 1'b0;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_CAPACITY: capacity_q <= pwdata[CAP_W-1:0];
				REG_MODE:     mode_q     <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CAPACITY: prdata = DATA_W'(capacity_q);
			REG_MODE:     prdata = DATA_W'(mode_q);
		endcase
	end

	// front: accepts and classifies items
	gcl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.cmd        (push_cmd),
		.q_full     (q_full)
	);

	// queue decouples loading from the selection engine
	gcl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.avail    (avail)
	);

	// back: weight store, greedy rounds, result register
	gcl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.capacity     (capacity_q),
		.mode         (mode_q),
		.cmd          (head),
		.cmd_avail    (avail),
		.cmd_pop      (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
